// ===== rtl/core/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// shared types and constants for the signed binary to decimal ascii block
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned QUOT_W  = 29;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;
    localparam logic [COUNT_W-1:0] MAX_DIGITS  = 4'd10;
    // reciprocal of ten, scaled by 2**35
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic sign;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic last_digit;
        logic idx_zero;
    } t_dp_status;

endpackage

// ===== rtl/core/sbda_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbda_ctrl
// sequencer: digit extraction loop, then sign and digits out msd first
// ----------------------------------------------------------------------------
module sbda_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  sbda_pkg::t_dp_status i_status,
    output sbda_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);
    import sbda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.last_digit) begin
                    n_state = ST_MUL;
                end else if (i_status.neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.idx_zero) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_MUL:  o_cmd.mul  = 1'b1;
            ST_DIV:  o_cmd.div  = 1'b1;
            ST_SIGN: o_cmd.sign = 1'b1;
            ST_EMIT: o_cmd.emit = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/sbda_datapath.sv =====
// ----------------------------------------------------------------------------
// sbda_datapath
// magnitude, reciprocal divide by ten, digit store and output register
// ----------------------------------------------------------------------------
module sbda_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [sbda_pkg::VALUE_W-1:0]   i_value,
    input  sbda_pkg::t_dp_cmd                     i_cmd,
    output sbda_pkg::t_dp_status                  o_status,
    output logic        [sbda_pkg::CHAR_W-1:0]    o_character,
    output logic                                  o_last,
    output logic                                  o_strobe
);
    import sbda_pkg::*;

    logic [VALUE_W-1:0] r_mag;
    logic [QUOT_W-1:0]  r_q;
    logic [DIGIT_W-1:0] r_digits [MAX_DIGITS];
    logic [COUNT_W-1:0] r_ndig;
    logic [COUNT_W-1:0] r_idx;
    logic               r_neg;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_strobe;

    logic [2*VALUE_W-1:0] w_prod;
    logic [VALUE_W:0]     w_q_ten;
    logic [DIGIT_W-1:0]   w_digit;
    logic [VALUE_W-1:0]   w_abs;

    assign w_abs   = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;
    assign w_prod  = r_mag * RECIP_TEN;
    // q * 10 as (q << 3) + (q << 1)
    assign w_q_ten = {1'b0, r_q, 3'b000} + {3'b000, r_q, 1'b0};
    // remainder is below ten, so the low nibble of the difference is exact
    assign w_digit = r_mag[DIGIT_W-1:0] - w_q_ten[DIGIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= w_abs;
            r_neg  <= i_value[VALUE_W-1];
            r_ndig <= '0;
        end
        if (i_cmd.mul) begin
            r_q <= w_prod[2*VALUE_W-1:RECIP_SHIFT];
        end
        if (i_cmd.div) begin
            r_digits[r_ndig] <= w_digit;
            r_ndig           <= r_ndig + 1'b1;
            r_mag            <= {{(VALUE_W-QUOT_W){1'b0}}, r_q};
            r_idx            <= r_ndig;
        end
        if (i_cmd.emit) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.sign) begin
            r_char <= ASCII_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit) begin
            r_char <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, r_digits[r_idx]};
            r_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.sign | i_cmd.emit;
        end
    end

    assign o_status.neg        = r_neg;
    assign o_status.last_digit = (r_q == '0) || (r_ndig == MAX_DIGITS - 1'b1);
    assign o_status.idx_zero   = (r_idx == '0);
    assign o_character         = r_char;
    assign o_last              = r_last;
    assign o_strobe            = r_strobe;

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per strobe
// ----------------------------------------------------------------------------
// sequence: with n digits (1 to 10), a multiply step and a divide step run
// per digit, then the sign (if negative) and the digits, most significant
// first, go out one character per cycle; a new item is taken only when busy
// is low again, once the last digit has been emitted
// reset: synchronous active low, returns to idle and clears the strobe
// the receiver cannot stall: every strobed character is taken at once
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sbda_pkg::VALUE_W-1:0] i_value,
    output logic        [sbda_pkg::CHAR_W-1:0]  o_character,
    output logic                                o_last,
    output logic                                o_strobe
);
    import sbda_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: idle, then multiply / divide per digit, then sign and digits
    sbda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // datapath: digits are taken least significant first into a small store,
    // then read back from the most significant end, so no reversal pass
    sbda_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_character (o_character),
        .o_last      (o_last),
        .o_strobe    (o_strobe)
    );

endmodule

// ===== rtl/core/sbda_checker.sv =====
// ----------------------------------------------------------------------------
// sbda_checker
// port-level checks on the decimal text output
// ----------------------------------------------------------------------------
module sbda_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [sbda_pkg::CHAR_W-1:0] o_character,
    input logic                        o_last,
    input logic                        o_strobe
);
    import sbda_pkg::*;

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accept did not raise busy");

    // only minus or a digit is ever shown
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_character == ASCII_MINUS) ||
                     (o_character >= ASCII_ZERO && o_character <= ASCII_ZERO + 6'd9))
        else $error("bad character code");

    // a minus sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_character == ASCII_MINUS) |-> !o_last)
        else $error("minus flagged last");

    // the text of one item is contiguous
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside text");

    // no new item while its text is still going out
    a_busy_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("idle inside text");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_character (o_character),
    .o_last      (o_last),
    .o_strobe    (o_strobe)
);
